FILE: design/lsd_pkg.sv
// Shared constants for the LZSS stream decoder.
// No dependencies; imported by the decoder core and its checker.
package lsd_pkg;

  // History window and derived address width
  localparam int WINDOW_SIZE = 4096;
  localparam int HIST_AW     = $clog2(WINDOW_SIZE);

  // Field widths
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 24;
  localparam int LEN_W  = 5;  // match length 2..17
  localparam int BITS_W = 4;  // flag bits left 0..8

  // Token phase codes
  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  // Fixed constants of the token format
  localparam logic [LEN_W-1:0]  MIN_MATCH  = LEN_W'(2);
  localparam logic [BITS_W-1:0] FLAG_COUNT = BITS_W'(8);

endpackage

FILE: design/lsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lzss_stream_decoder.sv
// LZSS stream decoder top level: token sequencer, history RAM, output register.
// Depends on lsd_pkg and lsd_ram.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one compressed byte per beat;
//   restart on a beat starts a new stream (counters and token state cleared,
//   history kept). Output channel (out_valid / out_stall) gives one
//   decompressed byte per beat; last_of_run marks the final byte caused by
//   an input beat, stream_done marks the byte that reaches output_length.
//   output_length is written through cfg_valid / cfg_ready / cfg_data by the user
//   only while the block is idle (the block does not enforce it); cfg_ready is always high.
// Sequence:
//   Flag bytes and low match bytes are accepted and produce nothing.
//   A literal is accepted, then emitted. A match is accepted and then
//   produces its bytes one by one: the history RAM read (registered)
//   and the write-back/emit go in turn for each byte.
//   Bytes show on the output ports in the cycle after they are emitted.
// Reset: rst is synchronous. History reads as zero after reset: a fill
//   mark over write_position tracks which slots were written, so there is
//   no clearing pass and the block is ready on the first cycle.
// Stall: a held output byte blocks the next emit; in_stall stays high
//   until the last byte of the current input beat is in the output register.
module lzss_stream_decoder (
  input  logic                         clk,
  input  logic                         rst,
  // compressed input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lsd_pkg::BYTE_W-1:0]   comp_byte,
  input  logic                         restart,
  // decompressed output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsd_pkg::BYTE_W-1:0]   out_byte,
  output logic                         last_of_run,
  output logic                         stream_done,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lsd_pkg::CNT_W-1:0]    cfg_data
);
  import lsd_pkg::*;

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LIT  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_DATA = 2'd3;

  logic [1:0]         state;
  logic [HIST_AW-1:0] wr_pos;
  logic               wrapped;
  logic [BYTE_W-1:0]  flag_bits;
  logic [BITS_W-1:0]  bits_left;
  logic [BITS_W-1:0]  bits_left_next;
  logic [BYTE_W-1:0]  held_low;
  logic [1:0]         phase;
  logic [CNT_W-1:0]   produced;
  logic [CNT_W-1:0]   output_length;
  logic [BYTE_W-1:0]  cur_byte;
  logic [HIST_AW-1:0] src;
  logic [LEN_W-1:0]   remaining;
  logic               rd_ok;
  logic [BYTE_W-1:0]  rd_data;

  logic               accept;
  logic [CNT_W-1:0]   eff_count;
  logic [1:0]         eff_phase;
  logic [BYTE_W-1:0]  eff_flags;
  logic               can_emit;
  logic               emit;
  logic               emit_last;
  logic               reaches;
  logic [CNT_W-1:0]   cnt_plus;
  logic [BYTE_W-1:0]  emit_byte;
  logic [HIST_AW-1:0] match_dist;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;

  // Token state as seen after a restart clear
  assign eff_count  = restart ? '0 : produced;
  assign eff_phase  = restart ? PH_FLAG : phase;
  assign eff_flags  = restart ? '0 : flag_bits;
  assign match_dist = {comp_byte, held_low[BYTE_W-1:4]};

  // Emit control: one byte into the output register and the history
  assign can_emit  = !out_valid || !out_stall;
  assign emit      = can_emit && ((state == ST_LIT) || (state == ST_DATA));
  assign cnt_plus  = produced + CNT_W'(1);
  assign reaches   = (cnt_plus == output_length);
  assign emit_last = (state == ST_LIT) || (remaining == LEN_W'(1)) || reaches;
  assign emit_byte = (state == ST_LIT) ? cur_byte : (rd_ok ? rd_data : '0);
  assign bits_left_next = (bits_left == '0) ? '0 : bits_left - BITS_W'(1);

  // History window
  lsd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (WINDOW_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (emit),
    .waddr (wr_pos),
    .wdata (emit_byte),
    .re    (state == ST_READ),
    .raddr (src),
    .rdata (rd_data)
  );

  // Payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= emit_byte;
      last_of_run <= emit_last;
      stream_done <= reaches;
    end
    if (accept && (eff_phase == PH_TOKEN) && eff_flags[0]) begin
      cur_byte <= comp_byte;
    end
    if (accept && (eff_phase == PH_HIGH)) begin
      src       <= wr_pos - match_dist;
      remaining <= LEN_W'(held_low[3:0]) + MIN_MATCH;
    end else if (emit && (state == ST_DATA)) begin
      src       <= src + HIST_AW'(1);
      remaining <= remaining - LEN_W'(1);
    end
    if (state == ST_READ) begin
      rd_ok <= wrapped || (src < wr_pos);
    end
  end

  // Sequencer and token state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      wr_pos        <= '0;
      wrapped       <= 1'b0;
      flag_bits     <= '0;
      bits_left     <= '0;
      held_low      <= '0;
      phase         <= PH_FLAG;
      produced      <= '0;
      output_length <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        output_length <= cfg_data;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (restart) begin
              produced <= '0;
              held_low <= '0;
            end
            if (eff_count < output_length) begin
              case (eff_phase)
                PH_TOKEN: begin
                  if (eff_flags[0]) begin
                    state <= ST_LIT;
                  end else begin
                    held_low <= comp_byte;
                    phase    <= PH_HIGH;
                  end
                end
                PH_HIGH: begin
                  state <= ST_READ;
                end
                default: begin
                  flag_bits <= comp_byte;
                  bits_left <= FLAG_COUNT;
                  phase     <= PH_TOKEN;
                end
              endcase
            end else if (restart) begin
              // new stream that is already finished
              phase     <= PH_FLAG;
              flag_bits <= '0;
              bits_left <= '0;
            end
          end
        end
        ST_READ: begin
          state <= ST_DATA;
        end
        ST_LIT, ST_DATA: begin
          if (emit) begin
            state <= emit_last ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Byte emitted: advance window and count, load output register
      if (emit) begin
        wr_pos    <= wr_pos + HIST_AW'(1);
        if (wr_pos == '1) begin
          wrapped <= 1'b1;
        end
        produced  <= cnt_plus;
        out_valid <= 1'b1;
        // token done: drop its flag bit
        if (emit_last) begin
          flag_bits <= flag_bits >> 1;
          bits_left <= bits_left_next;
          phase     <= (bits_left_next == '0) ? PH_FLAG : PH_TOKEN;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: design/lsd_checker.sv
// Port-level checker for the LZSS stream decoder, bound to the top level.
// Depends on lzss_stream_decoder.
module lsd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       stream_done
);

  // A held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte)
      && $stable(last_of_run) && $stable(stream_done))
    else $error("output beat changed while stalled");

  // While a run is incomplete the input side stays blocked
  a_busy_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> in_stall)
    else $error("input taken before run finished");

  // The stream end is always the end of a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_done |-> last_of_run)
    else $error("stream_done without last_of_run");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lzss_stream_decoder lsd_checker u_lsd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .last_of_run (last_of_run),
  .stream_done (stream_done)
);

FILE: verif/lzss_stream_decoder_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the LZSS stream decoder: watches the input, output and config
// channels, models the decoder and compares every output beat field by field.
// Depends on lsd_pkg.
module lzss_stream_decoder_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [lsd_pkg::BYTE_W-1:0] comp_byte,
  input  logic                       restart,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [lsd_pkg::BYTE_W-1:0] out_byte,
  input  logic                       last_of_run,
  input  logic                       stream_done,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [lsd_pkg::CNT_W-1:0]  cfg_data,
  output int                         outstanding,
  output int                         live_items,
  output int                         errors
);
  import lsd_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              done;
  } dec_beat_t;

  // Decoder model state
  logic [BYTE_W-1:0]  hist [WINDOW_SIZE];
  logic [HIST_AW-1:0] wr_pos;
  logic [BYTE_W-1:0]  flags;
  logic [BITS_W-1:0]  flags_left;
  logic [BYTE_W-1:0]  low_hold;
  logic [1:0]         phase;
  logic [CNT_W-1:0]   produced;
  logic [CNT_W-1:0]   out_len;

  dec_beat_t expected_bytes[$];
  int        live_cnt;
  int        err_cnt;

  task automatic report_mismatch(input string msg);
    $display("[%0t] checker: %s", $time, msg);
    err_cnt++;
  endtask

  // One decoded byte goes into the window and the expected queue
  task automatic put_byte(input logic [BYTE_W-1:0] b, input logic is_last);
    dec_beat_t e;
    hist[wr_pos] = b;
    wr_pos       = wr_pos + HIST_AW'(1);
    produced     = produced + CNT_W'(1);
    e.data = b;
    e.last = is_last;
    e.done = is_last && (produced == out_len);
    expected_bytes.push_back(e);
  endtask

  task automatic next_flag_bit();
    flags = flags >> 1;
    if (flags_left != '0) flags_left = flags_left - BITS_W'(1);
    phase = (flags_left == '0) ? PH_FLAG : PH_TOKEN;
  endtask

  // Model of one accepted input beat
  task automatic decode_beat(input logic [BYTE_W-1:0] b, input logic rs);
    logic [15:0]        word;
    logic [HIST_AW-1:0] src;
    logic [CNT_W-1:0]   room;
    int                 n;
    if (rs) begin
      produced   = '0;
      phase      = PH_FLAG;
      flags      = '0;
      flags_left = '0;
      low_hold   = '0;
    end
    // stream finished: byte is dropped
    if (produced >= out_len) return;
    live_cnt++;
    case (phase)
      PH_TOKEN: begin
        if (flags[0]) begin
          put_byte(b, 1'b1);
          next_flag_bit();
        end else begin
          low_hold = b;
          phase    = PH_HIGH;
        end
      end
      PH_HIGH: begin
        word = {b, low_hold};
        src  = wr_pos - word[15:4];
        room = out_len - produced;
        n    = int'(word[3:0]) + int'(MIN_MATCH);
        // match cut off at output_length
        if (room < CNT_W'(n)) n = int'(room);
        for (int i = 0; i < n; i++) begin
          put_byte(hist[src], i == n - 1);
          src = src + HIST_AW'(1);
        end
        next_flag_bit();
      end
      default: begin
        flags      = b;
        flags_left = FLAG_COUNT;
        phase      = PH_TOKEN;
      end
    endcase
  endtask

  task automatic check_beat();
    dec_beat_t e;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("out_byte 0x%02h with no byte expected", out_byte));
      return;
    end
    e = expected_bytes.pop_front();
    if (out_byte !== e.data)
      report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h", out_byte, e.data));
    if (last_of_run !== e.last)
      report_mismatch($sformatf("last_of_run %b, want %b (byte 0x%02h)",
                                last_of_run, e.last, e.data));
    if (stream_done !== e.done)
      report_mismatch($sformatf("stream_done %b, want %b (byte 0x%02h)",
                                stream_done, e.done, e.data));
  endtask

  // Sample all channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_SIZE; i++) hist[i] = '0;
      wr_pos     = '0;
      flags      = '0;
      flags_left = '0;
      low_hold   = '0;
      phase      = PH_FLAG;
      produced   = '0;
      out_len    = '0;
      live_cnt   = 0;
      err_cnt    = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_valid && cfg_ready) out_len = cfg_data;
      if (out_valid && !out_stall) check_beat();
      if (in_valid && !in_stall) decode_beat(comp_byte, restart);
    end
    outstanding <= expected_bytes.size();
    live_items  <= live_cnt;
    errors      <= err_cnt;
  end

endmodule

FILE: verif/lzss_stream_decoder_tb.sv
`timescale 1ns / 100ps
// Testbench top for the LZSS stream decoder: clock, reset, stimulus, output back-pressure
// and verdict. Depends on lsd_pkg, lzss_stream_decoder and lzss_stream_decoder_checker.
module lzss_stream_decoder_tb;
  import lsd_pkg::*;

  localparam int CLK_HALF         = 4;
  localparam int RESET_CYCLES     = 6;
  localparam int RANDOM_ITEMS     = 470;
  localparam int MAX_GAP          = 17;
  localparam int HOLD_AFTER_BEATS = 200;
  localparam int HOLD_CYCLES      = 400;
  localparam int SETTLE_CYCLES    = 8;
  localparam int TAIL_CYCLES      = 40;
  localparam int DRAIN_LIMIT      = 20000;
  localparam int RUN_LIMIT_NS     = 6_000_000;
  localparam logic [CNT_W-1:0] LEN_MAX = '1;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic [BYTE_W-1:0] comp_byte = '0;
  logic              restart   = 1'b0;
  logic              out_stall = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [CNT_W-1:0]  cfg_data  = '0;
  logic              in_stall;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              last_of_run;
  logic              stream_done;
  logic              cfg_ready;
  int                outstanding;
  int                live_items;
  int                errors;
  logic              tx_quiet  = 1'b0;
  logic              rx_quiet  = 1'b0;

  always #(CLK_HALF) clk = ~clk;

  lzss_stream_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .comp_byte   (comp_byte),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .stream_done (stream_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  lzss_stream_decoder_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .comp_byte   (comp_byte),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .stream_done (stream_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .live_items  (live_items),
    .errors      (errors)
  );

  // One compressed beat: random gap, then hold until accepted
  task automatic send_item(input logic [BYTE_W-1:0] b, input logic rs);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    comp_byte <= b;
    restart   <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Match word goes out low byte first
  task automatic send_match(input logic [HIST_AW-1:0] match_dist, input logic [3:0] code);
    logic [15:0] word;
    word = {match_dist, code};
    send_item(word[7:0], 1'b0);
    send_item(word[15:8], 1'b0);
  endtask

  // Drop valid, wait for every expected byte, then let a flag beat finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [CNT_W-1:0] len);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Flag byte plus its tokens; sometimes cut short, sometimes with stray bytes
  task automatic random_group(input logic first_rs);
    logic [BYTE_W-1:0]  flag;
    logic [HIST_AW-1:0] match_dist;
    int                 cut;
    int                 r;
    flag = BYTE_W'($urandom_range(0, 255));
    cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
    send_item(flag, first_rs);
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 24) == 0) send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
      if (flag[i]) begin
        send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
      end else begin
        // mostly short distances so copies hit recent output
        r = $urandom_range(0, 19);
        if (r == 0) match_dist = '0;
        else if (r < 14) match_dist = HIST_AW'($urandom_range(1, 40));
        else match_dist = HIST_AW'($urandom());
        send_match(match_dist, 4'($urandom_range(0, 15)));
      end
    end
  endtask

  task automatic random_phase();
    logic [CNT_W-1:0] len;
    int               r;
    int               groups;
    r = $urandom_range(0, 19);
    if (r == 0) len = '0;
    else if (r < 4) len = CNT_W'($urandom_range(1, 40));
    else if (r < 6) len = LEN_MAX;
    else len = CNT_W'($urandom_range(100, 3000));
    write_length(len);
    tx_quiet = ($urandom_range(0, 3) == 0);
    groups   = $urandom_range(1, 6);
    for (int g = 0; g < groups; g++)
      random_group((g == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 11) == 0));
  endtask

  // Stimulus and verdict
  initial begin
    int live_base;
    int drain;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // zero length: everything dropped
    write_length('0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);

    // max length: literal, overlapping copy, distance zero, far distance
    write_length(LEN_MAX);
    send_item(8'h05, 1'b1);
    send_item(8'hFF, 1'b0);
    send_match(12'd1, 4'hF);
    send_item(8'h00, 1'b0);
    send_match(12'd0, 4'h0);
    send_match(12'hFFF, 4'hF);
    send_match(12'd3, 4'h3);
    send_match(12'd18, 4'h0);
    send_match(12'd7, 4'h9);

    // match overruns the length, then the stream is finished
    write_length(CNT_W'(3));
    send_item(8'h00, 1'b1);
    send_match(12'd1, 4'hF);
    send_item(8'h12, 1'b0);

    // length lowered below the count, then a one-byte stream
    write_length(CNT_W'(1));
    send_item(8'hAA, 1'b0);
    send_item(8'h01, 1'b1);
    send_item(8'h5A, 1'b0);

    wait_idle();
    live_base = live_items;
    while (live_items < live_base + RANDOM_ITEMS) random_phase();

    // drain
    in_valid <= 1'b0;
    drain = 0;
    @(posedge clk);
    while (outstanding != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outstanding != 0) $display("checker: %0d expected bytes never arrived", outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Output back-pressure, with one long hold to fill the block
  initial begin
    int hold;
    int beats;
    beats = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (beats == HOLD_AFTER_BEATS) hold = HOLD_CYCLES;
      else hold = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      beats++;
      if (beats % 64 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
    end
  end

  // Run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule
